// ===== hw/rtl/scpt_pkg.sv =====
`default_nettype none

package scpt_pkg;

    localparam int MAX_VERTICES_DEF    = 16;
    localparam int COORD_FRAC_BITS_DEF = 30;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int TOL_W  = 21;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1024);

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scpt_mac.sv =====
`default_nettype none

module scpt_mac
    import scpt_pkg::*;
(
    input  wire logic                     clk,
    input  wire mac_ctrl_t                ctrl,
    input  wire logic signed [DATA_W-1:0] mul_a,
    input  wire logic signed [DATA_W-1:0] mul_b,
    output logic signed [ACC_W-1:0]       acc
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign prod_next = ACC_W'(mul_a) * ACC_W'(mul_b);

    // accumulate the registered product of the last issued multiply
    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scpt_nstore.sv =====
`default_nettype none

module scpt_nstore
    import scpt_pkg::*;
#(
    parameter int DEPTH = MAX_VERTICES_DEF,
    parameter int AW    = $clog2(MAX_VERTICES_DEF)
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic signed [DATA_W-1:0] wr_nx,
    input  wire logic signed [DATA_W-1:0] wr_ny,
    input  wire logic signed [DATA_W-1:0] wr_nz,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr,
    output logic signed [DATA_W-1:0]      rd_nx,
    output logic signed [DATA_W-1:0]      rd_ny,
    output logic signed [DATA_W-1:0]      rd_nz
);

    logic signed [DATA_W-1:0] mem_x [DEPTH];
    logic signed [DATA_W-1:0] mem_y [DEPTH];
    logic signed [DATA_W-1:0] mem_z [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_nx;
            mem_y[wr_addr] <= wr_ny;
            mem_z[wr_addr] <= wr_nz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_nx <= mem_x[rd_addr];
            rd_ny <= mem_y[rd_addr];
            rd_nz <= mem_z[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spherical_convex_polygon_test.sv =====
`default_nettype none

// Point-in-convex-polygon test on the unit sphere. A load word (cmd 0) adds a vertex;
// each vertex after the first stores the edge normal prev x cur, and a vertex with
// last_vertex set also stores the closing normal and completes the polygon (the next
// load starts a new one). A query word (cmd 1) reports inside_res = 1 when the point's
// dot product with every stored normal is at least -tolerance. All products go through
// one shared 32x32 multiplier with an accumulator, and the normals sit in a memory with
// one write port and one read port, so a load steps through the cross product for each
// normal it computes and a query reads and tests the stored normals (at most MAX_VERTICES)
// one by one, stopping at the first failure. A finished result waits in an output register
// while the next word is taken.
module spherical_convex_polygon_test
    import scpt_pkg::*;
#(
    parameter int MAX_VERTICES    = MAX_VERTICES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [TOL_W-1:0]         cfg_data,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic                     cmd,
    input  wire logic signed [DATA_W-1:0] x_coord,
    input  wire logic signed [DATA_W-1:0] y_coord,
    input  wire logic signed [DATA_W-1:0] z_coord,
    input  wire logic                     last_vertex,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic                          inside_res
);

    localparam int CW = COORD_FRAC_BITS + 2;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    localparam logic CMD_LOAD = 1'b0;

    localparam logic signed [DATA_W-1:0] COORD_ONE = DATA_W'(64'sd1 <<< COORD_FRAC_BITS);
    localparam logic signed [ACC_W-1:0]  SAT_HI =
        $signed((ACC_W'(1) << (DATA_W - 1)) - ACC_W'(1));
    localparam logic signed [ACC_W-1:0]  SAT_LO = -SAT_HI - ACC_W'(1);

    localparam logic [2:0] STEP_LAST_CROSS = 3'd7;
    localparam logic [2:0] STEP_CHECK      = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CROSS = 4'b0010,
        ST_QUERY = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > COORD_ONE)
            r = COORD_ONE;
        else if (v < -COORD_ONE)
            r = -COORD_ONE;
        else
            r = v;
        return CW'(r);
    endfunction

    // floor shift back to coordinate scale, then saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] norm_out(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        s = a >>> COORD_FRAC_BITS;
        if (s > SAT_HI)
            s = SAT_HI;
        else if (s < SAT_LO)
            s = SAT_LO;
        return DATA_W'(s);
    endfunction

    state_t          state_reg, state_next;
    logic [2:0]      step_reg, step_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [NW-1:0]   vcnt_reg, vcnt_next;
    logic [NW-1:0]   ecnt_reg, ecnt_next;
    logic            closed_reg, closed_next;
    logic            close_phase_reg, close_phase_next;
    logic            pend_close_reg, pend_close_next;
    logic            out_valid_reg, out_valid_next;
    logic [TOL_W-1:0] tol_reg, tol_next;

    logic signed [CW-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [CW-1:0] cur_x_next, cur_y_next, cur_z_next;
    logic signed [CW-1:0] first_x_reg, first_y_reg, first_z_reg;
    logic signed [CW-1:0] first_x_next, first_y_next, first_z_next;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [CW-1:0] prev_x_next, prev_y_next, prev_z_next;
    logic signed [DATA_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic            inside_reg, inside_next;
    logic            out_inside_reg, out_inside_next;

    logic                     accept;
    logic [NW-1:0]            v_eff, e_eff;
    logic signed [CW-1:0]     b_x, b_y, b_z;
    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  limit;
    logic                     wr_en, rd_en;
    logic signed [DATA_W-1:0] rd_nx, rd_ny, rd_nz;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign inside_res   = out_inside_reg;
    assign limit        = -$signed(ACC_W'(tol_reg) << COORD_FRAC_BITS);

    assign b_x = close_phase_reg ? first_x_reg : cur_x_reg;
    assign b_y = close_phase_reg ? first_y_reg : cur_y_reg;
    assign b_z = close_phase_reg ? first_z_reg : cur_z_reg;

    assign tol_next = cfg_write ? cfg_data : tol_reg;

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        idx_next         = idx_reg;
        vcnt_next        = vcnt_reg;
        ecnt_next        = ecnt_reg;
        closed_next      = closed_reg;
        close_phase_next = close_phase_reg;
        pend_close_next  = pend_close_reg;
        out_valid_next   = out_valid_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        cur_z_next       = cur_z_reg;
        first_x_next     = first_x_reg;
        first_y_next     = first_y_reg;
        first_z_next     = first_z_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        prev_z_next      = prev_z_reg;
        nx_next          = nx_reg;
        ny_next          = ny_reg;
        inside_next      = inside_reg;
        out_inside_next  = out_inside_reg;
        v_eff            = closed_reg ? '0 : vcnt_reg;
        e_eff            = closed_reg ? '0 : ecnt_reg;
        mac_ctrl         = '{mul_en: 1'b0, acc_op: ACC_HOLD};
        mul_a            = '0;
        mul_b            = '0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        // drop the result word once taken
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_x_next = clamp_coord(x_coord);
                    cur_y_next = clamp_coord(y_coord);
                    cur_z_next = clamp_coord(z_coord);
                    step_next  = '0;
                    if (cmd == CMD_LOAD)
                    begin
                        vcnt_next        = v_eff;
                        ecnt_next        = e_eff;
                        closed_next      = last_vertex;
                        pend_close_next  = last_vertex;
                        close_phase_next = 1'b0;
                        if (v_eff < NW'(MAX_VERTICES))
                        begin
                            vcnt_next = v_eff + NW'(1);
                            if (v_eff == '0)
                            begin
                                first_x_next = clamp_coord(x_coord);
                                first_y_next = clamp_coord(y_coord);
                                first_z_next = clamp_coord(z_coord);
                                prev_x_next  = clamp_coord(x_coord);
                                prev_y_next  = clamp_coord(y_coord);
                                prev_z_next  = clamp_coord(z_coord);
                                if (last_vertex)
                                begin
                                    close_phase_next = 1'b1;
                                    state_next       = ST_CROSS;
                                end
                            end
                            else
                            begin
                                state_next = ST_CROSS;
                            end
                        end
                        else if (last_vertex)
                        begin
                            close_phase_next = 1'b1;
                            state_next       = ST_CROSS;
                        end
                    end
                    else
                    begin
                        inside_next = 1'b1;
                        idx_next    = '0;
                        state_next  = (ecnt_reg == '0) ? ST_DONE : ST_QUERY;
                    end
                end
            end

            ST_CROSS:
            begin
                // A is prev, B is cur or first; even steps take (A, B), odd steps (B, A)
                case (step_reg)
                    3'd0: begin mul_a = DATA_W'(prev_y_reg); mul_b = DATA_W'(b_z); end
                    3'd1: begin mul_a = DATA_W'(b_y); mul_b = DATA_W'(prev_z_reg); end
                    3'd2: begin mul_a = DATA_W'(prev_z_reg); mul_b = DATA_W'(b_x); end
                    3'd3: begin mul_a = DATA_W'(b_z); mul_b = DATA_W'(prev_x_reg); end
                    3'd4: begin mul_a = DATA_W'(prev_x_reg); mul_b = DATA_W'(b_y); end
                    3'd5: begin mul_a = DATA_W'(b_x); mul_b = DATA_W'(prev_y_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                mac_ctrl.mul_en = (step_reg < 3'd6);
                case (step_reg)
                    3'd1, 3'd3, 3'd5: mac_ctrl.acc_op = ACC_LOAD;
                    3'd2, 3'd4, 3'd6: mac_ctrl.acc_op = ACC_SUB;
                    default:          mac_ctrl.acc_op = ACC_HOLD;
                endcase
                if (step_reg == 3'd3)
                begin
                    nx_next = norm_out(acc);
                end
                if (step_reg == 3'd5)
                begin
                    ny_next = norm_out(acc);
                end
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST_CROSS)
                begin
                    step_next = '0;
                    if (ecnt_reg < NW'(MAX_VERTICES))
                    begin
                        wr_en     = 1'b1;
                        ecnt_next = ecnt_reg + NW'(1);
                    end
                    if (!close_phase_reg)
                    begin
                        prev_x_next = cur_x_reg;
                        prev_y_next = cur_y_reg;
                        prev_z_next = cur_z_reg;
                        if (pend_close_reg)
                            close_phase_next = 1'b1;
                        else
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_QUERY:
            begin
                rd_en = (step_reg == 3'd0);
                case (step_reg)
                    3'd1: begin mul_a = rd_nx; mul_b = DATA_W'(cur_x_reg); end
                    3'd2: begin mul_a = rd_ny; mul_b = DATA_W'(cur_y_reg); end
                    3'd3: begin mul_a = rd_nz; mul_b = DATA_W'(cur_z_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                mac_ctrl.mul_en = (step_reg >= 3'd1) && (step_reg <= 3'd3);
                case (step_reg)
                    3'd2:       mac_ctrl.acc_op = ACC_LOAD;
                    3'd3, 3'd4: mac_ctrl.acc_op = ACC_ADD;
                    default:    mac_ctrl.acc_op = ACC_HOLD;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_CHECK)
                begin
                    step_next = '0;
                    if (acc < limit)
                    begin
                        inside_next = 1'b0;
                        state_next  = ST_DONE;
                    end
                    else if (NW'(idx_reg) + NW'(1) == ecnt_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = inside_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            idx_reg         <= '0;
            vcnt_reg        <= '0;
            ecnt_reg        <= '0;
            closed_reg      <= 1'b0;
            close_phase_reg <= 1'b0;
            pend_close_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            tol_reg         <= TOL_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            idx_reg         <= idx_next;
            vcnt_reg        <= vcnt_next;
            ecnt_reg        <= ecnt_next;
            closed_reg      <= closed_next;
            close_phase_reg <= close_phase_next;
            pend_close_reg  <= pend_close_next;
            out_valid_reg   <= out_valid_next;
            tol_reg         <= tol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        cur_z_reg      <= cur_z_next;
        first_x_reg    <= first_x_next;
        first_y_reg    <= first_y_next;
        first_z_reg    <= first_z_next;
        prev_x_reg     <= prev_x_next;
        prev_y_reg     <= prev_y_next;
        prev_z_reg     <= prev_z_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        inside_reg     <= inside_next;
        out_inside_reg <= out_inside_next;
    end

    scpt_mac u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc   (acc)
    );

    scpt_nstore #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_nstore (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ecnt_reg[AW-1:0]),
        .wr_nx   (nx_reg),
        .wr_ny   (ny_reg),
        .wr_nz   (norm_out(acc)),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_nx   (rd_nx),
        .rd_ny   (rd_ny),
        .rd_nz   (rd_nz)
    );

    a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecnt_reg <= NW'(MAX_VERTICES))
        else $error("edge count above capacity");

    a_closed_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && closed_reg) |-> (ecnt_reg == vcnt_reg))
        else $error("closed polygon has mismatched edge and vertex counts");

    a_open_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !closed_reg && vcnt_reg != '0)
        |-> (ecnt_reg == vcnt_reg - NW'(1)))
        else $error("open polygon edge count out of step with vertex count");

    a_query_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUERY) |-> (NW'(idx_reg) < ecnt_reg))
        else $error("query reads beyond stored normals");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done state");

endmodule

`default_nettype wire

// ===== dv/spherical_convex_polygon_test_tb.sv =====
module spherical_convex_polygon_test_tb;
    import scpt_pkg::*;

    localparam int FRAC        = COORD_FRAC_BITS_DEF;
    localparam int MAXV        = MAX_VERTICES_DEF;
    localparam int MAX_POLY    = 20;
    localparam int DRAIN_WAIT  = 120;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_DIRECTED  = 25;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [31:0] UNIT_C     = 32'h4000_0000;
    localparam logic [31:0] NEG_UNIT_C = 32'hC000_0000;
    localparam logic [31:0] HALF_C     = 32'h2000_0000;
    localparam logic [31:0] POS_MAX_C  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX_C  = 32'h8000_0000;

    localparam longint UNIT_Q = longint'(1) << FRAC;
    localparam real    PI_R   = 3.14159265358979;

    typedef struct packed {
        logic        cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
        logic        typed;
        logic        answer;
    } stim_row_t;

    // typed = 1 rows carry a hand-read answer, the rest go through the predictor
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{CMD_QUERY, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1},
        '{CMD_QUERY, UNIT_C, NEG_UNIT_C, UNIT_C, 1'b1, 1'b1, 1'b1},
        '{CMD_LOAD, UNIT_C, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, NEG_UNIT_C, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1},
        '{CMD_LOAD, 32'h0, UNIT_C, 32'h0, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, 32'h0, 32'h0, NEG_UNIT_C, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 32'h0, 32'h0, UNIT_C, 1'b1, 1'b0, 1'b0},
        '{CMD_QUERY, HALF_C, HALF_C, HALF_C, 1'b0, 1'b1, 1'b1},
        '{CMD_QUERY, NEG_UNIT_C, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0},
        '{CMD_QUERY, POS_MAX_C, POS_MAX_C, POS_MAX_C, 1'b0, 1'b1, 1'b1},
        '{CMD_QUERY, NEG_MAX_C, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0},
        '{CMD_QUERY, UNIT_C, 32'hFFFF_FC00, UNIT_C, 1'b0, 1'b1, 1'b1},
        '{CMD_QUERY, UNIT_C, 32'hFFFF_FBFF, UNIT_C, 1'b0, 1'b1, 1'b0},
        '{CMD_LOAD, 32'h0, UNIT_C, 32'h0, 1'b1, 1'b0, 1'b0},
        '{CMD_QUERY, NEG_UNIT_C, NEG_UNIT_C, NEG_UNIT_C, 1'b0, 1'b1, 1'b1},
        '{CMD_LOAD, 32'h0, UNIT_C, NEG_UNIT_C, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 32'h0, UNIT_C, UNIT_C, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, NEG_UNIT_C, NEG_UNIT_C, NEG_UNIT_C, 1'b1, 1'b0, 1'b0},
        '{CMD_QUERY, UNIT_C, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, NEG_UNIT_C, UNIT_C, 32'h0, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, NEG_MAX_C, POS_MAX_C, NEG_MAX_C, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0000_0001, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 32'h8765_4321, 32'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 1'b1, 1'b0, 1'b0},
        '{CMD_QUERY, 32'h0000_0400, 32'hFFFF_F000, 32'h3000_0000, 1'b0, 1'b0, 1'b0}
    };

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     cfg_write    = 1'b0;
    logic [TOL_W-1:0]         cfg_data     = '0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic                     cmd          = 1'b0;
    logic signed [DATA_W-1:0] x_coord      = '0;
    logic signed [DATA_W-1:0] y_coord      = '0;
    logic signed [DATA_W-1:0] z_coord      = '0;
    logic                     last_vertex  = 1'b0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic                     inside_res;

    // predictor state
    logic signed [31:0] nrm_x [MAXV];
    logic signed [31:0] nrm_y [MAXV];
    logic signed [31:0] nrm_z [MAXV];
    longint             first_x, first_y, first_z;
    longint             prev_x, prev_y, prev_z;
    int                 vtx_held   = 0;
    int                 nrm_count  = 0;
    bit                 poly_shut  = 1'b0;
    logic [TOL_W-1:0]   tol_slack  = TOL_RESET;

    bit inside_expected [$];
    bit inside_want;
    int errors     = 0;
    int words_sent = 0;
    int cycle_count = 0;
    int send_pct   = 0;
    int recv_pct   = 0;
    int stall_left = 0;

    // current polygon, used to aim queries
    logic signed [31:0] vtx_x [MAX_POLY];
    logic signed [31:0] vtx_y [MAX_POLY];
    logic signed [31:0] vtx_z [MAX_POLY];
    int  poly_n    = 1;
    int  poly_perm = 0;
    bit  poly_flip = 1'b0;
    real poly_r    = 0.5;

    spherical_convex_polygon_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .z_coord      (z_coord),
        .last_vertex  (last_vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .inside_res   (inside_res)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("spherical_convex_polygon_test_tb NOT OK");
            $finish;
        end
    end

    // random result-side stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (recv_pct != 0 && $urandom_range(0, 99) < recv_pct)
        begin
            stall_left   <= $urandom_range(0, 8);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (inside_expected.size() == 0)
            begin
                $error("inside_res: no word expected, actual %0b", inside_res);
                errors++;
            end
            else
            begin
                inside_want = inside_expected.pop_front();
                if (inside_res !== inside_want)
                begin
                    $error("inside_res: expected %0b, actual %0b", inside_want, inside_res);
                    errors++;
                end
            end
        end
    end

    function automatic longint clamp_coord(logic signed [31:0] raw);
        longint v;
        v = raw;
        if (v > UNIT_Q)
            return UNIT_Q;
        if (v < -UNIT_Q)
            return -UNIT_Q;
        return v;
    endfunction

    // floor((p - q) / 2^FRAC), saturated to 32 bits
    function automatic logic signed [31:0] cross_term(longint p, longint q);
        longint f;
        f = (p - q) >>> FRAC;
        if (f > 64'sd2147483647)
            return POS_MAX_C;
        if (f < -64'sd2147483648)
            return NEG_MAX_C;
        return f[31:0];
    endfunction

    task automatic add_normal(input longint ax, input longint ay, input longint az,
                              input longint bx, input longint by, input longint bz);
        if (nrm_count >= MAXV)
            return;
        nrm_x[nrm_count] = cross_term(ay * bz, by * az);
        nrm_y[nrm_count] = cross_term(az * bx, bz * ax);
        nrm_z[nrm_count] = cross_term(ax * by, bx * ay);
        nrm_count++;
    endtask

    task automatic absorb_vertex(input logic [31:0] rx, input logic [31:0] ry,
                                 input logic [31:0] rz, input logic lv);
        longint px, py, pz;
        px = clamp_coord(rx);
        py = clamp_coord(ry);
        pz = clamp_coord(rz);
        if (poly_shut)
        begin
            vtx_held  = 0;
            nrm_count = 0;
            poly_shut = 1'b0;
        end
        if (vtx_held < MAXV)
        begin
            if (vtx_held == 0)
            begin
                first_x = px;
                first_y = py;
                first_z = pz;
            end
            else
            begin
                add_normal(prev_x, prev_y, prev_z, px, py, pz);
            end
            prev_x = px;
            prev_y = py;
            prev_z = pz;
            vtx_held++;
        end
        if (lv)
        begin
            add_normal(prev_x, prev_y, prev_z, first_x, first_y, first_z);
            poly_shut = 1'b1;
        end
    endtask

    function automatic bit point_inside(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
        longint px, py, pz, floor_dot, d;
        px = clamp_coord(rx);
        py = clamp_coord(ry);
        pz = clamp_coord(rz);
        floor_dot = -(longint'(tol_slack) << FRAC);
        for (int k = 0; k < nrm_count; k++)
        begin
            d = longint'(nrm_x[k]) * px + longint'(nrm_y[k]) * py + longint'(nrm_z[k]) * pz;
            if (d < floor_dot)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_word(input logic c, input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic lv, input bit typed,
                             input bit want);
        if (send_pct != 0 && $urandom_range(0, 99) < send_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= c;
        x_coord     <= px;
        y_coord     <= py;
        z_coord     <= pz;
        last_vertex <= lv;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        if (c == CMD_LOAD)
            absorb_vertex(px, py, pz, lv);
        else
            inside_expected = {inside_expected, typed ? want : point_inside(px, py, pz)};
    endtask

    // hold off until every result is back and the block has gone quiet
    task automatic drain();
        item_valid <= 1'b0;
        while (inside_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        tol_slack = v;
    endtask

    function automatic real urand();
        return $urandom_range(0, 1000000) / 1000000.0;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return UNIT_C;
            2: return NEG_UNIT_C;
            3: return POS_MAX_C;
            4: return NEG_MAX_C;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return pick_extreme();
            default: return int'($urandom_range(0, 32'h8000_0000)) - int'(UNIT_C);
        endcase
    endfunction

    // rotate a local-frame direction into the polygon's frame, in Q30
    task automatic place(input real lx, input real ly, input real lz,
                         output logic [31:0] ox, output logic [31:0] oy,
                         output logic [31:0] oz);
        real a, b, c;
        case (poly_perm)
            0:
            begin
                a = lx; b = ly; c = lz;
            end
            1:
            begin
                a = lz; b = lx; c = ly;
            end
            default:
            begin
                a = ly; b = lz; c = lx;
            end
        endcase
        if (poly_flip)
        begin
            a = -a;
            b = -b;
        end
        ox = $rtoi(a * 1073741824.0);
        oy = $rtoi(b * 1073741824.0);
        oz = $rtoi(c * 1073741824.0);
    endtask

    task automatic send_probe();
        logic [31:0] qx, qy, qz;
        int  a, b, span, d;
        real ph, az;
        span = (poly_n < MAXV) ? poly_n : MAXV;
        a    = $urandom_range(0, span - 1);
        b    = (a + 1) % span;
        az   = 2.0 * PI_R * urand();
        case ($urandom_range(0, 9))
            0: place(0.0, 0.0, 1.0, qx, qy, qz);
            1, 2:
            begin
                ph = poly_r * 1.6 * urand();
                place($sin(ph) * $cos(az), $sin(ph) * $sin(az), $cos(ph), qx, qy, qz);
            end
            3:
            begin
                qx = vtx_x[a];
                qy = vtx_y[a];
                qz = vtx_z[a];
            end
            4:
            begin
                qx = 32'((longint'(vtx_x[a]) + longint'(vtx_x[b])) >>> 1);
                qy = 32'((longint'(vtx_y[a]) + longint'(vtx_y[b])) >>> 1);
                qz = 32'((longint'(vtx_z[a]) + longint'(vtx_z[b])) >>> 1);
            end
            5:
            begin
                d  = int'($urandom_range(0, 8192)) - 4096;
                qx = vtx_x[a] + d;
                d  = int'($urandom_range(0, 8192)) - 4096;
                qy = vtx_y[a] + d;
                d  = int'($urandom_range(0, 8192)) - 4096;
                qz = vtx_z[a] + d;
            end
            6:
            begin
                qx = $urandom;
                qy = $urandom;
                qz = $urandom;
            end
            7:
            begin
                qx = pick_extreme();
                qy = pick_extreme();
                qz = pick_extreme();
            end
            default:
            begin
                ph = PI_R * urand();
                place($sin(ph) * $cos(az), $sin(ph) * $sin(az), $cos(ph), qx, qy, qz);
            end
        endcase
        send_word(CMD_QUERY, qx, qy, qz, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
    endtask

    // vertices spread around a cap, mostly counterclockwise, then queries aimed at it
    task automatic run_polygon();
        int  n, pick, mid_q, j;
        real th;
        bit  rev, closes;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            n = 1;
        else if (pick < 12)
            n = 2;
        else if (pick < 80)
            n = $urandom_range(3, 8);
        else if (pick < 92)
            n = $urandom_range(9, MAXV);
        else
            n = $urandom_range(MAXV + 1, MAX_POLY);
        poly_perm = $urandom_range(0, 2);
        poly_flip = 1'($urandom_range(0, 1));
        poly_r    = 0.05 + 1.2 * urand();
        rev       = ($urandom_range(0, 9) == 0);
        closes    = ($urandom_range(0, 19) != 0);
        mid_q     = ($urandom_range(0, 6) == 0) ? $urandom_range(1, n) : -1;
        poly_n    = n;
        for (int i = 0; i < n; i++)
        begin
            j  = rev ? n - 1 - i : i;
            th = 2.0 * PI_R * (i + 0.8 * urand()) / n;
            place($sin(poly_r) * $cos(th), $sin(poly_r) * $sin(th), $cos(poly_r),
                  vtx_x[j], vtx_y[j], vtx_z[j]);
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == mid_q)
                send_probe();
            send_word(CMD_LOAD, vtx_x[i], vtx_y[i], vtx_z[i], closes && (i == n - 1),
                      1'b0, 1'b0);
        end
        repeat ($urandom_range(3, 10)) send_probe();
    endtask

    task automatic run_broken();
        int m;
        m = $urandom_range(1, 5);
        for (int i = 0; i < m; i++)
            send_word(CMD_LOAD, rand_coord(), rand_coord(), rand_coord(),
                      (i == m - 1) && ($urandom_range(0, 2) == 0), 1'b0, 1'b0);
        repeat ($urandom_range(1, 3))
            send_word(CMD_QUERY, rand_coord(), rand_coord(), rand_coord(),
                      1'($urandom_range(0, 1)), 1'b0, 1'b0);
    endtask

    task automatic run_random(input int target);
        int pick;
        while (words_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                run_polygon();
            else if (pick < 90)
                send_word(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, 3) == 0, 1'b0, 1'b0);
            else
                run_broken();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pct = 20;
        recv_pct = 20;
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y,
                      DIRECTED_ROWS[i].z, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].answer);

        drain();
        write_tolerance('0);
        send_pct = 30;
        recv_pct = 30;
        run_random(400);

        drain();
        write_tolerance({TOL_W{1'b1}});
        send_pct = 0;
        recv_pct = 50;
        run_random(750);

        drain();
        write_tolerance(TOL_W'(1048576));
        send_pct = 40;
        recv_pct = 0;
        run_random(1100);

        drain();
        write_tolerance(TOL_W'($urandom_range(0, 65535)));
        send_pct = 25;
        recv_pct = 25;
        run_random(1500);

        // last stretch runs with no random stalls on either side
        drain();
        write_tolerance(TOL_RESET);
        send_pct = 0;
        recv_pct = 0;
        run_random(1920);

        drain();
        if (errors == 0)
            $display("spherical_convex_polygon_test_tb OK");
        else
            $display("spherical_convex_polygon_test_tb NOT OK");
        $finish;
    end

endmodule
